// File: src/pqsa_pkg.sv
// Shared types, codes and constants for the priority scheduler with aging.
// Used by the remainder unit, the queue cells, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package pqsa_pkg;

	localparam int TID_W       = 16;
	localparam int PRIO_W      = 8;
	localparam int OUT_COUNT_W = 5;
	localparam int DEPTH_DEF   = 16;

	localparam logic [PRIO_W-1:0] LEVELS_RST = 8'd50;
	localparam logic [PRIO_W-1:0] PRIO_MAX   = 8'd255;

	// remainder unit retires this many dividend bits per cycle
	localparam int DIV_STEP_BITS = 4;
	localparam int DIV_CYCLES    = TID_W / DIV_STEP_BITS;

	localparam logic [1:0] OP_ENQ  = 2'd0;
	localparam logic [1:0] OP_DEQ  = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	// commands broadcast to every cell of the chain
	localparam logic [2:0] CELL_HOLD   = 3'd0;
	localparam logic [2:0] CELL_INSERT = 3'd1;
	localparam logic [2:0] CELL_REMOVE = 3'd2;
	localparam logic [2:0] CELL_AGE    = 3'd3;
	localparam logic [2:0] CELL_RESORT = 3'd4;

	typedef struct packed {
		logic [TID_W-1:0]  tid;
		logic [PRIO_W-1:0] prio;
	} entry_t;

	typedef struct packed {
		logic [2:0]        op;
		logic [TID_W-1:0]  tid;
		logic [PRIO_W-1:0] prio;
	} cell_cmd_t;

endpackage

`default_nettype wire

// File: src/pqsa_div.sv
// Remainder unit: task id modulo the level count, four quotient bits per cycle.
// Depends on pqsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pqsa_div
	import pqsa_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [TID_W-1:0]  dividend,
	input  wire logic [PRIO_W-1:0] divisor,
	output logic                   done,
	output logic [PRIO_W-1:0]      rem
);

	localparam int CNT_W = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [TID_W-1:0]  dvd_q;
	logic [PRIO_W-1:0] div_q;
	logic [PRIO_W-1:0] rem_q;
	logic [TID_W-1:0]  dvd_d;
	logic [PRIO_W-1:0] rem_d;

	// restoring steps; rem < divisor keeps the trial value inside PRIO_W+1 bits
	always_comb begin
		logic [PRIO_W:0] t;
		rem_d = rem_q;
		dvd_d = dvd_q;
		for (int k = 0; k < DIV_STEP_BITS; k++) begin
			t = {rem_d, dvd_d[TID_W-1]};
			dvd_d = dvd_d << 1;
			if (t >= {1'b0, div_q}) begin
				t = t - {1'b0, div_q};
			end
			rem_d = t[PRIO_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIV_CYCLES - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			// zero levels behaves as one level
			div_q <= (divisor == '0) ? PRIO_W'(1) : divisor;
		end else if (busy_q) begin
			dvd_q <= dvd_d;
			rem_q <= rem_d;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

// File: src/pqsa_cell.sv
// One slot of the sorted ready queue; shifts to and from its neighbors.
// Depends on pqsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pqsa_cell
	import pqsa_pkg::*;
#(
	parameter int CNT_W = 5,
	parameter int IDX   = 0
) (
	input  wire logic             clk,
	input  wire cell_cmd_t        cmd,
	input  wire logic [CNT_W-1:0] count,
	input  wire entry_t           ent_l,
	input  wire entry_t           ent_r,
	input  wire logic             cmp_l,
	input  wire logic             cmp_r,
	input  wire logic             hit_l,
	output entry_t                ent_o,
	output logic                  cmp_o,
	output logic                  hit_o
);

	entry_t ent_q;
	entry_t ent_d;
	entry_t fresh;
	logic   occ;
	logic   match;

	assign occ   = CNT_W'(IDX) < count;
	assign match = occ && (ent_q.tid == cmd.tid);
	// nearest-head match wins: everything from the first hit onward shifts
	assign hit_o = hit_l | match;
	// true when the new number belongs in front of this slot
	assign cmp_o = !occ || (ent_q.prio > cmd.prio);

	assign fresh.tid  = cmd.tid;
	assign fresh.prio = cmd.prio;

	always_comb begin
		ent_d = ent_q;
		unique case (cmd.op)
			CELL_INSERT: begin
				if (cmp_o) begin
					ent_d = cmp_l ? ent_l : fresh;
				end
			end
			CELL_REMOVE: begin
				if (hit_o) begin
					ent_d = ent_r;
				end
			end
			CELL_AGE: begin
				if (IDX == 0) begin
					ent_d.prio = cmd.prio;
				end
			end
			CELL_RESORT: begin
				// head leaves, the rest move up, head lands after its equals
				if (!cmp_r) begin
					ent_d = ent_r;
				end else if (IDX == 0 || !cmp_o) begin
					ent_d = fresh;
				end
			end
			default: ent_d = ent_q;
		endcase
	end

	always_ff @(posedge clk) begin
		ent_q <= ent_d;
	end

	assign ent_o = ent_q;

endmodule

`default_nettype wire

// File: src/priority_queue_scheduler_with_aging_unit.sv
// Priority scheduler with aging: a chain of QUEUE_DEPTH cells holds task ids
// sorted by ascending priority number, FIFO among equal numbers. An enqueue
// passes from the input transfer through the remainder unit, which turns the
// id into a priority number and retires four bits a cycle, then through the
// apply state, which updates the whole chain at once, and the report state,
// which loads the result register. Dequeue and tick skip the remainder unit.
// One item is in work at a time; the result register lets the next item in
// while a result still waits for its transfer.
// Depends on pqsa_pkg, pqsa_div, pqsa_cell.
`timescale 1ns / 1ps
`default_nettype none

module priority_queue_scheduler_with_aging_unit
	import pqsa_pkg::*;
#(
	parameter int QUEUE_DEPTH = DEPTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [1:0]             opcode,
	input  wire logic [TID_W-1:0]       task_id,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [TID_W-1:0]            head_task,
	output logic                        head_valid,
	output logic [PRIO_W-1:0]           head_priority,
	output logic [OUT_COUNT_W-1:0]      task_count,
	output logic                        reschedule,
	output logic [1:0]                  status,
	input  wire logic                   cfg_we,
	input  wire logic [PRIO_W-1:0]      cfg_data
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_DIV    = 2'd1;
	localparam logic [1:0] S_APPLY  = 2'd2;
	localparam logic [1:0] S_REPORT = 2'd3;

	logic [1:0]        state_q;
	logic [1:0]        op_q;
	logic [TID_W-1:0]  tid_q;
	logic [PRIO_W-1:0] levels_q;
	logic [CNT_W-1:0]  count_q;
	logic              rs_q;
	logic [1:0]        st_q;

	logic                   out_valid_q;
	logic [TID_W-1:0]       head_task_q;
	logic                   head_valid_q;
	logic [PRIO_W-1:0]      head_prio_q;
	logic [OUT_COUNT_W-1:0] count_out_q;
	logic                   resched_out_q;
	logic [1:0]             status_out_q;

	logic              accept;
	logic              div_done;
	logic [PRIO_W-1:0] div_rem;

	cell_cmd_t         cmd;
	logic [CNT_W-1:0]  count_d;
	logic              rs_d;
	logic [1:0]        st_d;
	logic [PRIO_W-1:0] aged;
	logic              full;
	logic              load_out;

	entry_t ent   [QUEUE_DEPTH];
	entry_t ent_l [QUEUE_DEPTH];
	entry_t ent_r [QUEUE_DEPTH];
	logic   cmp   [QUEUE_DEPTH];
	logic   cmp_l [QUEUE_DEPTH];
	logic   cmp_r [QUEUE_DEPTH];
	logic   hit   [QUEUE_DEPTH];
	logic   hit_l [QUEUE_DEPTH];

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign load_out = (state_q == S_REPORT) && (!out_valid_q || out_ready);

	pqsa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept && (opcode == OP_ENQ)),
		.dividend (task_id),
		.divisor  (levels_q),
		.done     (div_done),
		.rem      (div_rem)
	);

	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
		if (g == 0) begin : g_first
			assign ent_l[g] = '0;
			assign cmp_l[g] = 1'b0;
			assign hit_l[g] = 1'b0;
		end else begin : g_mid_l
			assign ent_l[g] = ent[g-1];
			assign cmp_l[g] = cmp[g-1];
			assign hit_l[g] = hit[g-1];
		end
		if (g == QUEUE_DEPTH - 1) begin : g_last
			assign ent_r[g] = '0;
			assign cmp_r[g] = 1'b1;
		end else begin : g_mid_r
			assign ent_r[g] = ent[g+1];
			assign cmp_r[g] = cmp[g+1];
		end

		pqsa_cell #(
			.CNT_W (CNT_W),
			.IDX   (g)
		) u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.count (count_q),
			.ent_l (ent_l[g]),
			.ent_r (ent_r[g]),
			.cmp_l (cmp_l[g]),
			.cmp_r (cmp_r[g]),
			.hit_l (hit_l[g]),
			.ent_o (ent[g]),
			.cmp_o (cmp[g]),
			.hit_o (hit[g])
		);
	end

	assign full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign aged = (ent[0].prio == PRIO_MAX) ? ent[0].prio : ent[0].prio + PRIO_W'(1);

	always_comb begin
		cmd.op   = CELL_HOLD;
		cmd.tid  = tid_q;
		cmd.prio = div_rem;
		count_d  = count_q;
		rs_d     = 1'b0;
		st_d     = ST_DONE;
		if (state_q == S_APPLY) begin
			case (op_q)
				OP_ENQ: begin
					if (full) begin
						st_d = ST_FULL;
					end else begin
						cmd.op  = CELL_INSERT;
						count_d = count_q + CNT_W'(1);
						rs_d    = (count_q != '0) && cmp[0];
					end
				end
				OP_DEQ: begin
					cmd.op = CELL_REMOVE;
					if (hit[QUEUE_DEPTH-1]) begin
						count_d = count_q - CNT_W'(1);
					end else begin
						st_d = ST_NOT_FOUND;
					end
				end
				OP_TICK: begin
					if (count_q != '0) begin
						cmd.prio = aged;
						if (count_q > CNT_W'(1) && aged > ent[1].prio) begin
							cmd.op  = CELL_RESORT;
							cmd.tid = ent[0].tid;
							rs_d    = 1'b1;
						end else begin
							cmd.op = CELL_AGE;
						end
					end
				end
				default: cmd.op = CELL_HOLD;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			levels_q    <= LEVELS_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				levels_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (opcode == OP_ENQ) ? S_DIV : S_APPLY;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					count_q <= count_d;
					state_q <= S_REPORT;
				end
				S_REPORT: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= opcode;
			tid_q <= task_id;
		end
		if (state_q == S_APPLY) begin
			rs_q <= rs_d;
			st_q <= st_d;
		end
		if (load_out) begin
			head_valid_q  <= (count_q != '0);
			head_task_q   <= (count_q != '0) ? ent[0].tid : '0;
			head_prio_q   <= (count_q != '0) ? ent[0].prio : '0;
			count_out_q   <= OUT_COUNT_W'(count_q);
			resched_out_q <= rs_q;
			status_out_q  <= st_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign head_task     = head_task_q;
	assign head_valid    = head_valid_q;
	assign head_priority = head_prio_q;
	assign task_count    = count_out_q;
	assign reschedule    = resched_out_q;
	assign status        = status_out_q;

endmodule

`default_nettype wire

// File: src/pqsa_checker.sv
// Port-level checks for the priority scheduler, bound to the top level.
// Depends on pqsa_pkg and priority_queue_scheduler_with_aging_unit.
`timescale 1ns / 1ps
`default_nettype none

module pqsa_checker
	import pqsa_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	input  wire logic                   in_ready,
	input  wire logic                   out_valid,
	input  wire logic                   out_ready,
	input  wire logic [TID_W-1:0]       head_task,
	input  wire logic                   head_valid,
	input  wire logic [PRIO_W-1:0]      head_priority,
	input  wire logic                   reschedule,
	input  wire logic [1:0]             status
);

	// one item in work at a time
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again right after a transfer");

	a_empty_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !head_valid |-> head_task == '0 && head_priority == '0)
		else $error("empty queue reports a head");

	a_full_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> head_valid && !reschedule)
		else $error("full status without a head");

	a_resched_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reschedule |-> head_valid && status == ST_DONE)
		else $error("reschedule flagged on an empty queue or failed item");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(head_task) && $stable(status))
		else $error("stalled result changed");

endmodule

bind priority_queue_scheduler_with_aging_unit pqsa_checker u_pqsa_checker (.*);

`default_nettype wire
